// File: hdl/tdtb_pkg.sv
package tdtb_pkg;

	localparam int SLOT_W    = 4;
	localparam int TICK_W    = 32;
	// the slot field is four bits wide, so no more slots than this can be named
	localparam int MAX_SLOTS = 16;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN
	} state_t;

	// contents of one timer cell
	typedef struct packed {
		logic [TICK_W-1:0] cnt;
		logic              mark;
		logic              expd;
	} cell_t;

	// per-cell strobes, at most one high in a cycle
	typedef struct packed {
		logic load;
		logic tick;
		logic shift;
	} cell_ctrl_t;

endpackage

// File: hdl/tdtb_if.sv
interface tdtb_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [tdtb_pkg::SLOT_W-1:0] task_slot;
	logic [tdtb_pkg::TICK_W-1:0] delay_ticks;
	logic                        waits_for_event;

	modport source (output valid, op, task_slot, delay_ticks, waits_for_event, input ready);
	modport sink   (input valid, op, task_slot, delay_ticks, waits_for_event, output ready);
endinterface

interface tdtb_evt_if;
	logic                        valid;
	logic                        ready;
	logic                        expiry_valid;
	logic [tdtb_pkg::SLOT_W-1:0] expired_slot;
	logic                        timeout_hit;
	logic [tdtb_pkg::TICK_W-1:0] tick_count;
	logic                        last;

	modport source (output valid, expiry_valid, expired_slot, timeout_hit, tick_count, last,
		input ready);
	modport sink   (input valid, expiry_valid, expired_slot, timeout_hit, tick_count, last,
		output ready);
endinterface

// File: hdl/tdtb_cell.sv
module tdtb_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tdtb_pkg::cell_ctrl_t        ctrl,
	input  logic [tdtb_pkg::TICK_W-1:0] load_cnt,
	input  logic                        load_mark,
	input  tdtb_pkg::cell_t             nbr,
	output tdtb_pkg::cell_t             cur
);

	tdtb_pkg::cell_t cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (ctrl.load) begin
			cell_q.cnt  <= load_cnt;
			cell_q.mark <= load_mark;
			cell_q.expd <= 1'b0;
		end else if (ctrl.tick) begin
			// idle counters stay at zero and never expire
			if (cell_q.cnt != '0) begin
				cell_q.cnt  <= cell_q.cnt - tdtb_pkg::TICK_W'(1);
				cell_q.expd <= (cell_q.cnt == tdtb_pkg::TICK_W'(1));
			end else begin
				cell_q.expd <= 1'b0;
			end
		end else if (ctrl.shift) begin
			cell_q <= nbr;
		end
	end

	assign cur = cell_q;

endmodule

// File: hdl/task_delay_timer_bank.sv
// Task delay timer bank: a 32-bit wrapping tick count plus one 32-bit delay
// counter and waits-for-event mark per task slot, held in a ring of timer
// cells. A set-delay item gives no result; a set-delay for a slot at or above
// the slot count is dropped. A tick item steps every nonzero counter down in
// its accepting cycle, then looks for expiries in the check state; if any
// expired, the ring rotates once, one slot a cycle, past cell 0 so that
// expired slots come out in ascending order. When nothing expires, the
// rotation is skipped and a single result with expiry_valid low comes out.
// Rotation pauses while an expired head cell waits for the output register
// to free. The command channel is only ready between items.
module task_delay_timer_bank #(
	parameter int TASK_SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	tdtb_cmd_if.sink      cmd,
	tdtb_evt_if.source    evt
);

	// only slots that the four-bit slot field can name exist
	localparam int LIVE  = (TASK_SLOTS < tdtb_pkg::MAX_SLOTS) ? TASK_SLOTS
		: tdtb_pkg::MAX_SLOTS;
	localparam int IDX_W = (LIVE > 1) ? $clog2(LIVE) : 1;

	// ring of cells
	tdtb_pkg::cell_t      cells [LIVE];
	tdtb_pkg::cell_t      nbrs  [LIVE];
	tdtb_pkg::cell_ctrl_t ctrls [LIVE];
	logic [LIVE-1:0]      exp_vec;
	logic                 rest_exp;

	// sequencer
	tdtb_pkg::state_t     state_q;
	tdtb_pkg::state_t     state_nxt;
	logic [IDX_W-1:0]     idx_q;
	logic [tdtb_pkg::TICK_W-1:0] ticks_q;

	logic cmd_ready_c;
	logic do_set;
	logic do_tick;
	logic do_shift;
	logic emit;
	logic emit_valid;
	logic emit_last;
	logic can_load;
	logic scan_done;

	// output register
	logic                        evt_valid_q;
	logic                        exp_valid_q;
	logic [tdtb_pkg::SLOT_W-1:0] slot_q;
	logic                        tmo_q;
	logic [tdtb_pkg::TICK_W-1:0] tick_out_q;
	logic                        last_q;

	genvar i;
	generate
		for (i = 0; i < LIVE; i++) begin : g_cell
			// each cell hands its contents down by one place; the wrap-around
			// into the top cell drops the expiry flag, which has been served
			if (i == LIVE - 1) begin : g_wrap
				always_comb begin
					nbrs[i]      = cells[0];
					nbrs[i].expd = 1'b0;
				end
			end else begin : g_link
				assign nbrs[i] = cells[i + 1];
			end

			assign ctrls[i].load  = do_set && (cmd.task_slot == tdtb_pkg::SLOT_W'(i));
			assign ctrls[i].tick  = do_tick;
			assign ctrls[i].shift = do_shift;
			assign exp_vec[i]     = cells[i].expd;

			tdtb_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrls[i]),
				.load_cnt  (cmd.delay_ticks),
				.load_mark (cmd.waits_for_event),
				.nbr       (nbrs[i]),
				.cur       (cells[i])
			);
		end
	endgenerate

	// any expiry still to pass the head after the one at cell 0
	assign rest_exp  = |(exp_vec >> 1);
	assign can_load  = !evt_valid_q || evt.ready;
	assign scan_done = (idx_q == IDX_W'(LIVE - 1));
	assign cmd.ready = cmd_ready_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdtb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		cmd_ready_c = 1'b0;
		do_set      = 1'b0;
		do_tick     = 1'b0;
		do_shift    = 1'b0;
		emit        = 1'b0;
		emit_valid  = 1'b0;
		emit_last   = 1'b0;
		case (state_q)
			tdtb_pkg::ST_IDLE: begin
				cmd_ready_c = 1'b1;
				if (cmd.valid) begin
					if (tdtb_pkg::op_t'(cmd.op) == tdtb_pkg::OP_SET) begin
						do_set = 1'b1;
					end else begin
						do_tick   = 1'b1;
						state_nxt = tdtb_pkg::ST_CHECK;
					end
				end
			end
			tdtb_pkg::ST_CHECK: begin
				// a quiet tick gives one empty result and skips the rotation
				if (|exp_vec) begin
					state_nxt = tdtb_pkg::ST_SCAN;
				end else if (can_load) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_nxt = tdtb_pkg::ST_IDLE;
				end
			end
			tdtb_pkg::ST_SCAN: begin
				// an expired head holds the ring until the output register frees
				if (!exp_vec[0] || can_load) begin
					do_shift = 1'b1;
					if (exp_vec[0]) begin
						emit       = 1'b1;
						emit_valid = 1'b1;
						emit_last  = !rest_exp;
					end
					if (scan_done) begin
						state_nxt = tdtb_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = tdtb_pkg::ST_IDLE;
			end
		endcase
	end

	// slot number of the cell now at the head of the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (do_shift) begin
			idx_q <= scan_done ? '0 : idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
		end else if (do_tick) begin
			ticks_q <= ticks_q + tdtb_pkg::TICK_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (emit) begin
			evt_valid_q <= 1'b1;
		end else if (evt.ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			exp_valid_q <= emit_valid;
			slot_q      <= emit_valid ? tdtb_pkg::SLOT_W'(idx_q) : '0;
			tmo_q       <= emit_valid && cells[0].mark;
			tick_out_q  <= ticks_q;
			last_q      <= emit_last;
		end
	end

	assign evt.valid        = evt_valid_q;
	assign evt.expiry_valid = exp_valid_q;
	assign evt.expired_slot = slot_q;
	assign evt.timeout_hit  = tmo_q;
	assign evt.tick_count   = tick_out_q;
	assign evt.last         = last_q;

endmodule

// File: verif/task_delay_timer_bank_monitor.sv
`timescale 1ns / 1ps

module task_delay_timer_bank_monitor #(
	parameter int TASK_SLOTS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	tdtb_cmd_if   cmd,
	tdtb_evt_if   evt,
	output int    fail_count,
	output int    pending
);

	localparam int LIVE_SLOTS = (TASK_SLOTS < tdtb_pkg::MAX_SLOTS) ? TASK_SLOTS
		: tdtb_pkg::MAX_SLOTS;

	typedef struct packed {
		logic                        expiry_valid;
		logic [tdtb_pkg::SLOT_W-1:0] expired_slot;
		logic                        timeout_hit;
		logic [tdtb_pkg::TICK_W-1:0] tick_count;
		logic                        last;
	} expiry_t;

	logic [tdtb_pkg::TICK_W-1:0] remaining [tdtb_pkg::MAX_SLOTS];
	logic                        event_mark [tdtb_pkg::MAX_SLOTS];
	logic [tdtb_pkg::TICK_W-1:0] tick_now;
	expiry_t                     due_expiries [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic report(input string what);
		fail_count++;
		$display("%0t ns  %s", $time, what);
	endtask

	// advance the timer bank by one accepted item and queue its expiries
	task automatic absorb_item();
		expiry_t fresh [$];
		expiry_t r;
		if (tdtb_pkg::op_t'(cmd.op) == tdtb_pkg::OP_SET) begin
			if (int'(cmd.task_slot) < LIVE_SLOTS) begin
				remaining[cmd.task_slot]  = cmd.delay_ticks;
				event_mark[cmd.task_slot] = cmd.waits_for_event;
			end
		end else begin
			tick_now = tick_now + 1'b1;
			for (int s = 0; s < LIVE_SLOTS; s++) begin
				if (remaining[s] != '0) begin
					remaining[s] = remaining[s] - 1'b1;
					if (remaining[s] == '0) begin
						r.expiry_valid = 1'b1;
						r.expired_slot = tdtb_pkg::SLOT_W'(s);
						r.timeout_hit  = event_mark[s];
						r.tick_count   = tick_now;
						r.last         = 1'b0;
						fresh.push_back(r);
					end
				end
			end
			if (fresh.size() == 0) begin
				r.expiry_valid = 1'b0;
				r.expired_slot = '0;
				r.timeout_hit  = 1'b0;
				r.tick_count   = tick_now;
				r.last         = 1'b1;
				fresh.push_back(r);
			end else begin
				r = fresh.pop_back();
				r.last = 1'b1;
				fresh.push_back(r);
			end
			foreach (fresh[i]) due_expiries.push_back(fresh[i]);
		end
	endtask

	task automatic check_expiry();
		expiry_t want;
		if (due_expiries.size() == 0) begin
			report($sformatf("unexpected result slot %0d tick %0d",
				evt.expired_slot, evt.tick_count));
		end else begin
			want = due_expiries.pop_front();
			if (evt.expiry_valid !== want.expiry_valid)
				report($sformatf("expiry_valid %b, want %b", evt.expiry_valid,
					want.expiry_valid));
			if (evt.expired_slot !== want.expired_slot)
				report($sformatf("expired_slot %0d, want %0d", evt.expired_slot,
					want.expired_slot));
			if (evt.timeout_hit !== want.timeout_hit)
				report($sformatf("timeout_hit %b, want %b (slot %0d)", evt.timeout_hit,
					want.timeout_hit, want.expired_slot));
			if (evt.tick_count !== want.tick_count)
				report($sformatf("tick_count %0d, want %0d", evt.tick_count,
					want.tick_count));
			if (evt.last !== want.last)
				report($sformatf("last %b, want %b (slot %0d)", evt.last, want.last,
					want.expired_slot));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < tdtb_pkg::MAX_SLOTS; s++) begin
				remaining[s]  = '0;
				event_mark[s] = 1'b0;
			end
			tick_now = '0;
			due_expiries.delete();
		end else begin
			// results are registered, so an item taken now cannot answer now
			if (evt.valid && evt.ready) check_expiry();
			if (cmd.valid && cmd.ready) absorb_item();
		end
		pending = due_expiries.size();
	end

endmodule

// File: verif/task_delay_timer_bank_tb.sv
`timescale 1ns / 1ps

module task_delay_timer_bank_tb;

	localparam int SLOTS = 16;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	// idle chances in percent per cycle, changed between phases
	int   send_idle;
	int   recv_idle;

	tdtb_cmd_if cmd ();
	tdtb_evt_if evt ();

	task_delay_timer_bank #(
		.TASK_SLOTS(SLOTS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.evt    (evt)
	);

	task_delay_timer_bank_monitor #(
		.TASK_SLOTS(SLOTS)
	) expiry_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.evt        (evt),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// known values on every input from time zero
	initial begin
		arst_n              = 1'b0;
		cmd.valid           = 1'b0;
		cmd.op              = tdtb_pkg::OP_TICK;
		cmd.task_slot       = '0;
		cmd.delay_ticks     = '0;
		cmd.waits_for_event = 1'b0;
		evt.ready           = 1'b0;
		send_idle           = 9;
		recv_idle           = 59;
	end

	// receiver back-pressure, decided afresh every cycle
	always @(posedge clk) begin
		evt.ready <= ($urandom_range(99) >= recv_idle);
	end

	// hand one item to the block; valid only drops when the sender idles
	task automatic send_item(input tdtb_pkg::op_t op,
		input logic [tdtb_pkg::SLOT_W-1:0] slot,
		input logic [tdtb_pkg::TICK_W-1:0] delay, input logic waits);
		while ($urandom_range(99) < send_idle) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid           <= 1'b1;
		cmd.op              <= op;
		cmd.task_slot       <= slot;
		cmd.delay_ticks     <= delay;
		cmd.waits_for_event <= waits;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
	endtask

	task automatic tick();
		// slot and delay are don't-cares on a tick, so fill them with noise
		send_item(tdtb_pkg::OP_TICK, tdtb_pkg::SLOT_W'($urandom), $urandom, 1'($urandom));
	endtask

	// hard stop in case the block hangs
	initial begin
		#2ms;
		$display("task_delay_timer_bank: mismatch");
		$finish;
	end

	initial begin
		tdtb_pkg::op_t               op;
		logic [tdtb_pkg::TICK_W-1:0] delay;
		int                          roll;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: a tick with nothing pending gives one invalid result
		tick();
		// both ends of the slot range expiring on the same tick, one with a timeout
		send_item(tdtb_pkg::OP_SET, 4'd0, 32'd1, 1'b1);
		send_item(tdtb_pkg::OP_SET, 4'd15, 32'd1, 1'b0);
		tick();
		// zero delay leaves the slot idle
		send_item(tdtb_pkg::OP_SET, 4'd3, 32'd0, 1'b1);
		tick();
		// longest possible delay, then cleared again
		send_item(tdtb_pkg::OP_SET, 4'd5, 32'hFFFF_FFFF, 1'b1);
		tick();
		send_item(tdtb_pkg::OP_SET, 4'd5, 32'd0, 1'b0);
		// mark is kept after expiry and only replaced by the next load
		send_item(tdtb_pkg::OP_SET, 4'd7, 32'd1, 1'b1);
		tick();
		send_item(tdtb_pkg::OP_SET, 4'd7, 32'd2, 1'b0);
		tick();
		tick();
		// every slot expiring on one tick: the largest burst of results
		for (int s = 0; s < SLOTS; s++) begin
			send_item(tdtb_pkg::OP_SET, tdtb_pkg::SLOT_W'(s), 32'd2, 1'(s));
		end
		tick();
		tick();

		// random part in three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 9;
					recv_idle = 59;
				end
				1: begin
					send_idle = 59;
					recv_idle = 9;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int n = 0; n < 130; n++) begin
				op = ($urandom_range(99) < 45) ? tdtb_pkg::OP_TICK : tdtb_pkg::OP_SET;
				if (op == tdtb_pkg::OP_TICK) begin
					tick();
				end else begin
					// mostly short delays so expiries keep coming
					roll = $urandom_range(99);
					if (roll < 70)      delay = $urandom_range(6, 1);
					else if (roll < 80) delay = '0;
					else                delay = $urandom;
					send_item(tdtb_pkg::OP_SET, tdtb_pkg::SLOT_W'($urandom), delay,
						1'($urandom));
				end
			end
		end

		// drain: every expected result out, then a tail to catch strays
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (fail_count == 0) begin
			$display("task_delay_timer_bank: match");
		end else begin
			$display("task_delay_timer_bank: mismatch");
		end
		$finish;
	end

endmodule
